[sv/swamm_pkg.sv]
// ---------------------------------------------------------------------------
// swamm_pkg: shared types and constants
// Data widths, register map constants and the command/status bundles that
// join the controller and the datapath of the sliding-window statistics block.
// ---------------------------------------------------------------------------
package swamm_pkg;

	// sample and result width
	localparam int DATA_W  = 32;
	// width of the window register field
	localparam int CFG_W   = 9;
	// APB address and data widths
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;
	// smallest allowed window
	localparam int MIN_WIN = 2;

	// register index (paddr[2])
	localparam logic REG_WINDOW = 1'b0;

	typedef logic signed [DATA_W-1:0] data_t;

	// min/max markers after a clear
	localparam data_t MIN_INIT = 32'sh7FFF_FFFF;
	localparam data_t MAX_INIT = -32'sd1;

	// controller -> datapath commands
	typedef struct packed {
		logic take;       // input transfer: capture sample, read old slot
		logic upd;        // update ring, sum, pointer, count, min/max
		logic scan_rd;    // issue one rescan read
		logic div_start;  // launch the divider
		logic load_out;   // load the output register
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic rescan;     // evicted sample was the tracked min or max
		logic scan_last;  // rescan read address is the last window entry
		logic div_done;   // quotient ready
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

[sv/swamm_if.sv]
// ---------------------------------------------------------------------------
// swamm_if: valid/ready channels
// Input channel carries one sample, output channel carries average, minimum
// and maximum. A transfer happens when valid and ready are both high.
// ---------------------------------------------------------------------------
interface swamm_in_if;
	import swamm_pkg::*;

	logic  valid;
	logic  ready;
	data_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swamm_out_if;
	import swamm_pkg::*;

	logic  valid;
	logic  ready;
	data_t average;
	data_t minimum;
	data_t maximum;

	modport source (output valid, output average, output minimum, output maximum,
		input ready);
	modport sink   (input valid, input average, input minimum, input maximum,
		output ready);
endinterface

[sv/swamm_div.sv]
// ---------------------------------------------------------------------------
// swamm_div: iterative signed-by-unsigned divider
// Restoring division on the magnitude, one quotient bit per cycle, sign
// applied at the end so the quotient truncates toward zero.
// ---------------------------------------------------------------------------
module swamm_div #(
	parameter int SUM_W = 40,
	parameter int CNT_W = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [SUM_W-1:0]     dividend,
	input  logic        [CNT_W-1:0]     divisor,
	output logic                        done,
	output logic [swamm_pkg::DATA_W-1:0] quot
);
	import swamm_pkg::*;

	localparam int CW = $clog2(SUM_W);

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [CNT_W:0]   trial;
	logic             ge;
	logic [CNT_W:0]   diff;
	logic [SUM_W-1:0] signed_quo;

	// one trial subtraction
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift/subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[SUM_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quot       = signed_quo[DATA_W-1:0];
	assign done       = done_q;

endmodule

[sv/swamm_dp.sv]
// ---------------------------------------------------------------------------
// swamm_dp: datapath
// Sample ring memory, running sum, tracked min/max, pointers, window
// register, divider and output register.
// ---------------------------------------------------------------------------
module swamm_dp #(
	parameter int WINDOW_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swamm_pkg::cmd_t                 cmd,
	output swamm_pkg::sts_t                 sts,
	input  swamm_pkg::data_t                in_sample,
	input  logic                            cfg_wr,
	input  logic [swamm_pkg::CFG_W-1:0]     cfg_data,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0] win_size,
	output logic                            out_valid,
	input  logic                            out_ready,
	output swamm_pkg::data_t                average,
	output swamm_pkg::data_t                minimum,
	output swamm_pkg::data_t                maximum
);
	import swamm_pkg::*;

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = DATA_W + AW;

	// ring memory, no reset: the fill count masks unwritten slots
	data_t win_mem_q [WINDOW_DEPTH];
	data_t rdata_q;

	data_t                    sample_q;
	logic [CNT_W-1:0]         win_q;
	logic [AW-1:0]            wptr_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	data_t                    min_q;
	data_t                    max_q;
	logic [AW-1:0]            scan_idx_q;
	logic                     scan_v_s1;
	logic                     first_s1;
	logic                     out_valid_q;
	data_t                    average_q;
	data_t                    minimum_q;
	data_t                    maximum_q;

	logic                     full;
	logic [AW-1:0]            raddr;
	logic [SUM_W-1:0]         old_ext;
	logic [SUM_W-1:0]         smp_ext;
	logic [CNT_W-1:0]         slot_inc;
	logic [31:0]              cfg_w32;
	logic [CNT_W-1:0]         cfg_clamped;
	logic                     div_done;
	data_t                    quot;

	// window register clamp
	assign cfg_w32 = 32'(cfg_data);
	always_comb begin
		if (cfg_w32 < 32'(MIN_WIN))
			cfg_clamped = CNT_W'(MIN_WIN);
		else if (cfg_w32 > 32'(WINDOW_DEPTH))
			cfg_clamped = CNT_W'(WINDOW_DEPTH);
		else
			cfg_clamped = cfg_w32[CNT_W-1:0];
	end

	// ring memory: write new sample on update, read old slot or scan entry
	assign raddr = cmd.scan_rd ? scan_idx_q : wptr_q;
	always_ff @(posedge clk) begin
		if (cmd.upd)
			win_mem_q[wptr_q] <= sample_q;
		if (cmd.take || cmd.scan_rd)
			rdata_q <= win_mem_q[raddr];
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.take)
			sample_q <= in_sample;
	end

	// evicted value counts only once the window is full
	assign full     = count_q >= win_q;
	assign old_ext  = full ? {{(SUM_W-DATA_W){rdata_q[DATA_W-1]}}, rdata_q} : '0;
	assign smp_ext  = {{(SUM_W-DATA_W){sample_q[DATA_W-1]}}, sample_q};
	assign slot_inc = CNT_W'(wptr_q) + 1'b1;

	// window state: register, pointer, count, sum, min/max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= CNT_W'(MIN_WIN);
			wptr_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= MIN_INIT;
			max_q   <= MAX_INIT;
		end else if (cfg_wr) begin
			win_q   <= cfg_clamped;
			wptr_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= MIN_INIT;
			max_q   <= MAX_INIT;
		end else if (cmd.upd) begin
			sum_q  <= sum_q + $signed(smp_ext - old_ext);
			wptr_q <= (slot_inc >= win_q) ? '0 : slot_inc[AW-1:0];
			if (count_q < win_q)
				count_q <= count_q + 1'b1;
			// incremental min/max unless a rescan follows
			if (!sts.rescan) begin
				if (count_q == '0) begin
					min_q <= sample_q;
					max_q <= sample_q;
				end else begin
					if (sample_q < min_q)
						min_q <= sample_q;
					if (sample_q > max_q)
						max_q <= sample_q;
				end
			end
		end else if (scan_v_s1) begin
			// rescan accumulation, one entry per cycle
			if (first_s1) begin
				min_q <= rdata_q;
				max_q <= rdata_q;
			end else begin
				if (rdata_q < min_q)
					min_q <= rdata_q;
				if (rdata_q > max_q)
					max_q <= rdata_q;
			end
		end
	end

	// rescan address counter and read-data tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			scan_v_s1  <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			if (cmd.upd)
				scan_idx_q <= '0;
			else if (cmd.scan_rd)
				scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (scan_idx_q == '0);
	end

	// average = sum / count
	swamm_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quot     (quot)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			average_q <= quot;
			minimum_q <= min_q;
			maximum_q <= max_q;
		end
	end

	// status
	assign sts.rescan    = full && (rdata_q == min_q || rdata_q == max_q);
	assign sts.scan_last = CNT_W'(scan_idx_q) == (win_q - CNT_W'(1));
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign win_size  = win_q;
	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign minimum   = minimum_q;
	assign maximum   = maximum_q;

endmodule

[sv/swamm_ctrl.sv]
// ---------------------------------------------------------------------------
// swamm_ctrl: controller
// Sequences one item: old-slot read, update, optional rescan, division and
// hand-off to the output register.
// ---------------------------------------------------------------------------
module swamm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output swamm_pkg::cmd_t cmd,
	input  swamm_pkg::sts_t sts
);
	import swamm_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_UPD  = 7'b0000010,
		ST_SCAN = 7'b0000100,
		ST_TAIL = 7'b0001000,
		ST_DIVS = 7'b0010000,
		ST_DIVW = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.take      = in_valid && in_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.rescan ? ST_SCAN : ST_DIVS;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last)
					state_d = ST_TAIL;
			end
			ST_TAIL: begin
				// last scan entry lands this cycle
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (sts.div_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[sv/sliding_window_avg_min_max.sv]
// ---------------------------------------------------------------------------
// sliding_window_avg_min_max: moving average with window minimum and maximum
// Each input sample yields one result: average, minimum and maximum over the
// last window_size samples. One item at a time; the output register lets
// the next sample in while a result waits.
// ---------------------------------------------------------------------------
// The evicted slot is read at the input transfer itself. After that the
// ring and running sum are updated, the iterative divider is started and
// works through the quotient bits, the controller sees the quotient and then
// loads the output register once that register is free. The next sample is
// taken back in the idle state. When the window is full and the evicted
// sample was the tracked minimum or maximum, a rescan of the ring memory
// reads every window entry, one entry per read port cycle, before the
// division starts. The window register sits at byte address 0; a write
// clamps it to 2..WINDOW_DEPTH and empties the window. Write it only while
// idle.
module sliding_window_avg_min_max #(
	parameter int WINDOW_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	swamm_in_if.sink                        in_ch,
	swamm_out_if.source                     out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [swamm_pkg::ADDR_W-1:0]    paddr,
	input  logic [swamm_pkg::PDATA_W-1:0]   pwdata,
	output logic [swamm_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import swamm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

	cmd_t             cmd;
	sts_t             sts;
	logic             cfg_wr;
	logic [CNT_W-1:0] win_size;

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
	assign prdata = (paddr[2] == REG_WINDOW) ? PDATA_W'(win_size) : '0;

	swamm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	swamm_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_sample (in_ch.sample),
		.cfg_wr    (cfg_wr),
		.cfg_data  (pwdata[CFG_W-1:0]),
		.win_size  (win_size),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.average   (out_ch.average),
		.minimum   (out_ch.minimum),
		.maximum   (out_ch.maximum)
	);

endmodule

[sv/swamm_chk.sv]
// ---------------------------------------------------------------------------
// swamm_chk: port-level checks
// Watches the channels and the register port of the top level.
// ---------------------------------------------------------------------------
module swamm_chk #(
	parameter int WINDOW_DEPTH = 256
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input swamm_pkg::data_t              average,
	input swamm_pkg::data_t              minimum,
	input swamm_pkg::data_t              maximum,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [swamm_pkg::ADDR_W-1:0]  paddr,
	input logic [swamm_pkg::PDATA_W-1:0] prdata
);
	import swamm_pkg::*;

	// one item in flight: the input closes after a transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open right after a transfer");

	// a new result is only raised while an item is being worked on
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no item in progress");

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average) &&
		$stable(minimum) && $stable(maximum))
		else $error("stalled result changed");

	// window register reads back clamped after a write
	a_win_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=>
		(paddr[2] != REG_WINDOW) ||
		(prdata >= PDATA_W'(MIN_WIN) && prdata <= PDATA_W'(WINDOW_DEPTH)))
		else $error("window register out of range");

endmodule

bind sliding_window_avg_min_max swamm_chk #(
	.WINDOW_DEPTH (WINDOW_DEPTH)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.average   (out_ch.average),
	.minimum   (out_ch.minimum),
	.maximum   (out_ch.maximum),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.prdata    (prdata)
);
